>>> hdl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types, codes and constants shared by the sorted list table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL_POS = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL_KEY = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

  // index register update
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_COUNT = 3'd1;
  localparam logic [2:0] IDX_POS   = 3'd2;
  localparam logic [2:0] IDX_ZERO  = 3'd3;
  localparam logic [2:0] IDX_INC   = 3'd4;
  localparam logic [2:0] IDX_DEC   = 3'd5;

  // read address select, relative to the index
  localparam logic [1:0] RA_CUR  = 2'd0;
  localparam logic [1:0] RA_PREV = 2'd1;
  localparam logic [1:0] RA_NEXT = 2'd2;

  // write data select
  localparam logic WD_VAL = 1'b0;
  localparam logic WD_RD  = 1'b1;

  // count update
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        entry_count;
  } out_item_t;

  typedef struct packed {
    logic              load_item;
    logic [2:0]        idx_op;
    logic              rd_en;
    logic [1:0]        rd_sel;
    logic              wr_en;
    logic              wr_sel;
    logic [1:0]        cnt_op;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              set_rdv;
    logic              load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic            full;
    logic            pos_bad;
    logic            count_zero;
    logic            idx_is_one;
    logic            idx_last;
    logic            idx_end;
    logic            rd_lt_val;
    logic            rd_eq_val;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/slt_datapath.sv
// ----------------------------------------------------------------------------
// slt_datapath
// Entry memory, index and count registers, compares and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_datapath
  import slt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire ctl_cmd_t  cmd,
  output dp_stat_t       stat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [VALUE_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]           op_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [POS_W-1:0]          pos_r;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic signed [VALUE_W-1:0] rd_data_r;
  logic [STAT_W-1:0]         status_r;
  logic signed [VALUE_W-1:0] rdv_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic [CW-1:0]      idx_m1, idx_p1, pos_m1;
  logic [CW-1:0]      rd_idx;
  logic [VALUE_W-1:0] wr_data;

  assign idx_m1 = idx_r - CW'(1);
  assign idx_p1 = idx_r + CW'(1);
  assign pos_m1 = CW'(pos_r - POS_W'(1));

  always_comb begin
    case (cmd.rd_sel)
      RA_PREV: rd_idx = idx_m1;
      RA_NEXT: rd_idx = idx_p1;
      default: rd_idx = idx_r;
    endcase
  end

  assign wr_data = (cmd.wr_sel == WD_RD) ? rd_data_r : val_r;

  always_comb begin
    case (cmd.idx_op)
      IDX_COUNT: idx_nxt = count_r;
      IDX_POS:   idx_nxt = pos_m1;
      IDX_ZERO:  idx_nxt = '0;
      IDX_INC:   idx_nxt = idx_p1;
      IDX_DEC:   idx_nxt = idx_m1;
      default:   idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + CW'(1);
      CNT_DEC: count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  // entry store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx_r[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= in_data.operation;
      val_r <= in_data.value;
      pos_r <= in_data.position;
    end
    idx_r <= idx_nxt;
    if (cmd.load_item) begin
      status_r <= ST_DONE;
      rdv_r    <= '0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.set_rdv) begin
        rdv_r <= rd_data_r;
      end
    end
    if (cmd.load_out) begin
      out_data_r.status      <= status_r;
      out_data_r.read_value  <= rdv_r;
      out_data_r.entry_count <= COUNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.operation  = op_r;
    stat.full       = (count_r == CW'(CAPACITY));
    stat.pos_bad    = (pos_r == '0) || (CMPW'(pos_r) > CMPW'(count_r));
    stat.count_zero = (count_r == '0);
    stat.idx_is_one = (idx_r == CW'(1));
    stat.idx_last   = (idx_p1 >= count_r);
    stat.idx_end    = (idx_r >= count_r);
    stat.rd_lt_val  = (rd_data_r < val_r);
    stat.rd_eq_val  = (rd_data_r == val_r);
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hdl/slt_ctrl.sv
// ----------------------------------------------------------------------------
// slt_ctrl
// Sequencer for search, shift and result hand-off of one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ctrl
  import slt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_EV  = 4'd3;
  localparam logic [3:0] S_INS_PUT = 4'd4;
  localparam logic [3:0] S_DEL     = 4'd5;
  localparam logic [3:0] S_DEL_RD  = 4'd6;
  localparam logic [3:0] S_DEL_EV  = 4'd7;
  localparam logic [3:0] S_KEY     = 4'd8;
  localparam logic [3:0] S_KEY_RD  = 4'd9;
  localparam logic [3:0] S_KEY_EV  = 4'd10;
  localparam logic [3:0] S_GET_RD  = 4'd11;
  localparam logic [3:0] S_GET_EV  = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.operation)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              cmd.idx_op = IDX_COUNT;
              state_nxt  = stat.count_zero ? S_INS_PUT : S_INS_RD;
            end
          end
          OP_DEL_KEY: begin
            cmd.idx_op = IDX_ZERO;
            state_nxt  = S_KEY;
          end
          default: begin
            if (stat.pos_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_MISSING;
              state_nxt      = S_DONE;
            end else begin
              cmd.idx_op = IDX_POS;
              state_nxt  = (stat.operation == OP_READ) ? S_GET_RD : S_DEL;
            end
          end
        endcase
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_PREV;
        state_nxt  = S_INS_EV;
      end
      S_INS_EV: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_lt_val) begin
          cmd.wr_sel = WD_VAL;
          cmd.cnt_op = CNT_INC;
          state_nxt  = S_DONE;
        end else begin
          cmd.wr_sel = WD_RD;
          cmd.idx_op = IDX_DEC;
          state_nxt  = stat.idx_is_one ? S_INS_PUT : S_INS_RD;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_VAL;
        cmd.cnt_op = CNT_INC;
        state_nxt  = S_DONE;
      end
      S_DEL: begin
        if (stat.idx_last) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_NEXT;
        state_nxt  = S_DEL_EV;
      end
      S_DEL_EV: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_RD;
        cmd.idx_op = IDX_INC;
        state_nxt  = S_DEL;
      end
      S_KEY: begin
        if (stat.idx_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_MISSING;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_CUR;
        state_nxt  = S_KEY_EV;
      end
      S_KEY_EV: begin
        if (stat.rd_eq_val) begin
          state_nxt = S_DEL;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_KEY;
        end
      end
      S_GET_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_CUR;
        state_nxt  = S_GET_EV;
      end
      S_GET_EV: begin
        cmd.set_rdv = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sorted_list_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Ascending table of signed 32-bit values with insert, delete and read.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel, one operation per transfer (insert sorted,
//           delete at 1-based position, delete first equal key, read at
//           position). out_* : valid/ready channel, one result per operation
//           carrying status, read value (zero unless a read succeeded) and
//           the entry count after the operation.
//   Timing: one item at a time, through a single registered read port; a new
//           item is taken only once the sequencer is back in idle. Insert
//           shifts every entry not less than the value up from the end, one
//           at a time; delete at pos shifts the later entries down; delete
//           by key scans from the front, then shifts as delete at pos; read
//           is one read. A full insert or a bad position is rejected at once.
//   Stall:  results sit in an output register; a new item is taken while an
//           earlier result waits, and the sequencer holds a finished result
//           until that register frees up.
//   Reset:  rst_n (synchronous, active low) empties the list and drops any
//           pending result. Entry storage itself is not cleared; only
//           entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table_unit
  import slt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // command and status between sequencer and datapath
  ctl_cmd_t cmd;
  dp_stat_t stat;

  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> test/sorted_list_table_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_table_unit_tb
// Drives insert, delete and read operations through the input channel. Each
// result is scored against an in-bench model of the ascending table or a typed
// answer. A directed table of rows comes first, then a long random run. Both
// channels idle at random, and one long result hold-off backs the block up.
// ----------------------------------------------------------------------------
module sorted_list_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int CAPACITY       = DEF_CAPACITY;
  localparam int RANDOM_ITEMS   = 400;
  localparam int HOLD_AT        = 80;    // result number at which the sink holds off
  localparam int HOLD_CYCLES    = 250;   // length of that hold-off
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 10;
  localparam int WATCHDOG_LIMIT = 2000;  // well above the hold-off plus a full walk
  localparam int REPORT_LIMIT   = 10;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  sorted_list_table_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Table model: ascending signed entries plus the count. Only entries below
  // held_total are meaningful.
  // --------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] held_values [CAPACITY];
  int unsigned               held_total;

  out_item_t pending_results[$];   // results owed by the block, oldest first
  int        mismatch_count;
  int        idle_cycles;

  function automatic void remove_entry(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < held_total; i++) begin
      held_values[i] = held_values[i + 1];
    end
    held_total--;
  endfunction

  // Applies one operation to the model and returns the result it owes.
  function automatic out_item_t predict_table_op(input in_item_t op_item);
    out_item_t   res;
    int unsigned at;
    res = '0;
    res.status = ST_DONE;
    case (op_item.operation)
      OP_INSERT: begin
        if (held_total >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          at = 0;
          // strict less-than, so a new value lands in front of its equals
          while (at < held_total && held_values[at] < op_item.value) at++;
          for (int unsigned i = held_total; i > at; i--) begin
            held_values[i] = held_values[i - 1];
          end
          held_values[at] = op_item.value;
          held_total++;
        end
      end
      OP_DEL_POS: begin
        if (op_item.position == 0 || op_item.position > held_total) begin
          res.status = ST_MISSING;
        end else begin
          remove_entry(op_item.position - 1);
        end
      end
      OP_DEL_KEY: begin
        at = 0;
        while (at < held_total && held_values[at] != op_item.value) at++;
        if (at >= held_total) begin
          res.status = ST_MISSING;
        end else begin
          remove_entry(at);
        end
      end
      default: begin  // OP_READ
        if (op_item.position == 0 || op_item.position > held_total) begin
          res.status = ST_MISSING;
        end else begin
          res.read_value = held_values[op_item.position - 1];
        end
      end
    endcase
    res.entry_count = held_total[COUNT_W-1:0];
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected st=%0d rd=%0d cnt=%0d, got st=%0d rd=%0d cnt=%0d",
               $realtime, what, want.status, want.read_value, want.entry_count,
               got.status, got.read_value, got.entry_count);
    end
  endfunction

  // Per-item wait draw, with occasional calm stretches of
  // back-to-back transfers.
  function automatic int draw_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(20, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Inputs move on the falling edge; transfers are seen at the rising
  // edge. The model is stepped at the transfer, so it always reflects what
  // the block has taken.
  // --------------------------------------------------------------------------
  int sender_calm;

  task automatic send_item(input in_item_t item, input bit typed, input out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = predict_table_op(item);
    // directed rows with an answer typed in are scored against that answer
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Random operation mix. A fill/drain phase swings the table between empty
  // and full, so the full-list and empty-list paths both get exercised.
  bit fill_phase = 1'b1;

  function automatic in_item_t next_random_item();
    in_item_t item;
    int       pick;
    int       small_val;
    if (held_total >= CAPACITY) fill_phase = 1'b0;
    else if (held_total == 0) fill_phase = 1'b1;
    else if ($urandom_range(0, 59) == 0) fill_phase = !fill_phase;

    pick = $urandom_range(0, 99);
    if (fill_phase) begin
      item.operation = (pick < 55) ? OP_INSERT : (pick < 65) ? OP_DEL_POS :
                       (pick < 80) ? OP_DEL_KEY : OP_READ;
    end else begin
      item.operation = (pick < 15) ? OP_INSERT : (pick < 50) ? OP_DEL_POS :
                       (pick < 80) ? OP_DEL_KEY : OP_READ;
    end

    // values: mostly a small pool so duplicates and key hits are common
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      small_val  = int'($urandom_range(0, 15)) - 8;
      item.value = small_val;
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0:       item.value = VAL_MIN;
        1:       item.value = VAL_MAX;
        2:       item.value = -32'sd1;
        default: item.value = '0;
      endcase
    end else begin
      item.value = $urandom;
    end
    if (item.operation == OP_DEL_KEY && held_total > 0 && $urandom_range(0, 9) < 7) begin
      item.value = held_values[$urandom_range(0, held_total - 1)];
    end

    // positions: mostly in range, otherwise anything the field can hold
    if (held_total > 0 && $urandom_range(0, 9) < 8) begin
      item.position = POS_W'($urandom_range(1, held_total));
    end else begin
      item.position = POS_W'($urandom_range(0, 31));
    end
    return item;
  endfunction

  // --------------------------------------------------------------------------
  // Directed rows. reps > 1 repeats the same transfer; typed rows carry the
  // answer read straight off the table's state.
  // --------------------------------------------------------------------------
  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t want;
  } step_t;

  function automatic step_t row(input logic [OP_W-1:0] op,
                                input logic signed [VALUE_W-1:0] val,
                                input logic [POS_W-1:0] pos, input int reps,
                                input bit typed, input logic [STAT_W-1:0] st,
                                input logic signed [VALUE_W-1:0] rd,
                                input logic [COUNT_W-1:0] cnt);
    step_t s;
    s.item.operation   = op;
    s.item.value       = val;
    s.item.position    = pos;
    s.reps             = reps;
    s.typed            = typed;
    s.want.status      = st;
    s.want.read_value  = rd;
    s.want.entry_count = cnt;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: random stalls, one long hold-off, and the scoreboard check.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int        stall;
    int        taken;
    int        sink_calm;
    out_item_t want;
    out_ready = 1'b0;
    taken     = 0;
    sink_calm = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait(sink_calm);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;  // let the block back up
      if (stall > 0) begin
        out_ready <= 1'b0;
        for (int c = 0; c < stall; c++) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status ||
            out_data.read_value !== want.read_value ||
            out_data.entry_count !== want.entry_count) begin
          flag_mismatch("result mismatch", want, out_data);
        end
      end
      taken++;
      @(negedge clk);
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    step_t directed_steps[$];
    step_t s;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    held_total     = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    sender_calm    = 0;
    foreach (held_values[i]) held_values[i] = '0;

    // empty table: every lookup misses
    directed_steps.push_back(row(OP_READ,    '0,      5'd1,  1, 1, ST_MISSING, '0, 5'd0));
    directed_steps.push_back(row(OP_DEL_POS, '0,      5'd0,  1, 1, ST_MISSING, '0, 5'd0));
    directed_steps.push_back(row(OP_DEL_KEY, '0,      5'd0,  1, 1, ST_MISSING, '0, 5'd0));
    // first insert into an empty table, then both extremes
    directed_steps.push_back(row(OP_INSERT,  '0,      5'd0,  1, 1, ST_DONE,    '0, 5'd1));
    directed_steps.push_back(row(OP_INSERT,  VAL_MIN, 5'd31, 1, 1, ST_DONE,    '0, 5'd2));
    directed_steps.push_back(row(OP_INSERT,  VAL_MAX, 5'd0,  1, 1, ST_DONE,    '0, 5'd3));
    directed_steps.push_back(row(OP_READ,    '0,      5'd1,  1, 1, ST_DONE, VAL_MIN, 5'd3));
    directed_steps.push_back(row(OP_READ,    '0,      5'd3,  1, 1, ST_DONE, VAL_MAX, 5'd3));
    // position zero, beyond the count, and the top of the field
    directed_steps.push_back(row(OP_READ,    '0,      5'd0,  1, 1, ST_MISSING, '0, 5'd3));
    directed_steps.push_back(row(OP_READ,    '0,      5'd31, 1, 1, ST_MISSING, '0, 5'd3));
    directed_steps.push_back(row(OP_DEL_POS, '0,      5'd4,  1, 1, ST_MISSING, '0, 5'd3));
    // fill with equal values, then insert into the full table
    directed_steps.push_back(row(OP_INSERT,  32'sd5,  5'd0, 13, 0, ST_DONE,    '0, 5'd0));
    directed_steps.push_back(row(OP_INSERT,  32'sd7,  5'd0,  1, 1, ST_FULL,    '0, 5'd16));
    directed_steps.push_back(row(OP_READ,    '0,      5'd16, 1, 1, ST_DONE, VAL_MAX, 5'd16));
    // key delete among duplicates, then deletes at both ends
    directed_steps.push_back(row(OP_DEL_KEY, 32'sd5,  5'd0,  1, 1, ST_DONE,    '0, 5'd15));
    directed_steps.push_back(row(OP_DEL_POS, '0,      5'd15, 1, 1, ST_DONE,    '0, 5'd14));
    directed_steps.push_back(row(OP_DEL_POS, '0,      5'd1,  1, 1, ST_DONE,    '0, 5'd13));
    directed_steps.push_back(row(OP_DEL_KEY, -32'sd1, 5'd0,  1, 1, ST_MISSING, '0, 5'd13));
    directed_steps.push_back(row(OP_INSERT,  -32'sd1, 5'd0,  1, 1, ST_DONE,    '0, 5'd14));
    directed_steps.push_back(row(OP_READ,    '0,      5'd1,  1, 1, ST_DONE, -32'sd1, 5'd14));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      repeat (s.reps) send_item(s.item, s.typed, s.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_item(next_random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/slt_pkg.sv
hdl/slt_datapath.sv
hdl/slt_ctrl.sv
hdl/sorted_list_table_unit.sv
test/sorted_list_table_unit_tb.sv
